// ----- design/keyboard_scan_fifo_with_status_core_assert.svh -----
// assertion macros for the keyboard scan queue modules
// no dependencies; included by kbs_queue, the only module that carries assertions
`ifndef KEYBOARD_SCAN_FIFO_WITH_STATUS_CORE_ASSERT_SVH
`define KEYBOARD_SCAN_FIFO_WITH_STATUS_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define KBS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("kbs assertion failed");

// condition must never be true outside reset
`define KBS_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("kbs forbidden condition seen");

`else

`define KBS_ASSERT(label, clk, rst, prop)
`define KBS_NEVER(label, clk, rst, cond)

`endif

`endif

// ----- design/kbs_pkg.sv -----
// shared types and constants for the keyboard scan queue
// no dependencies
package kbs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W = 3;
  localparam int CODE_W = 7;
  localparam int BYTE_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_PRESS       = 3'd0,
    OP_RELEASE     = 3'd1,
    OP_READ_STATE  = 3'd2,
    OP_WRITE_STATE = 3'd3,
    OP_READ_DATA   = 3'd4
  } op_t;

  localparam logic [BYTE_W-1:0] BIT_ACTIVE = 8'h01;
  localparam logic [BYTE_W-1:0] BIT_NUM    = 8'h02;
  localparam logic [BYTE_W-1:0] BIT_CAPS   = 8'h04;
  localparam logic [BYTE_W-1:0] BIT_SCROLL = 8'h08;
  localparam logic [BYTE_W-1:0] BIT_BUSY   = 8'h80;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              key_dropped;
  } result_t;

endpackage

// ----- design/kbs_queue.sv -----
// scan code queue, lock lights and per-transfer result logic
// depends on kbs_pkg and the assertion macro header
`include "keyboard_scan_fifo_with_status_core_assert.svh"

module kbs_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [kbs_pkg::OP_W-1:0]     opcode,
  input  logic [kbs_pkg::CODE_W-1:0]   scan_code,
  input  logic [kbs_pkg::BYTE_W-1:0]   write_value,
  output kbs_pkg::result_t             res
);
  import kbs_pkg::*;

  logic [BYTE_W-1:0] scan_store [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_index;
  logic [PTR_W-1:0]  tail_index;
  logic [CNT_W-1:0]  entry_count;
  logic              num_light;
  logic              caps_light;
  logic              scroll_light;

  logic              is_key;
  logic              full;
  logic              empty;
  logic              push;
  logic              pop;
  logic [BYTE_W-1:0] key_byte;
  logic [BYTE_W-1:0] state_byte;
  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail_next;

  assign is_key = (opcode == OP_PRESS) || (opcode == OP_RELEASE);
  assign full   = (entry_count == CNT_W'(QUEUE_DEPTH));
  assign empty  = (entry_count == '0);
  assign push   = take && is_key && !full;
  assign pop    = take && (opcode == OP_WRITE_STATE) && !empty
                  && ((write_value & BIT_BUSY) == '0);

  assign key_byte = (opcode == OP_RELEASE) ? ({1'b0, scan_code} | BIT_BUSY)
                                           : {1'b0, scan_code};

  assign head_next = (head_index == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                             : head_index + PTR_W'(1);
  assign tail_next = (tail_index == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                             : tail_index + PTR_W'(1);

  always_comb begin
    state_byte = BIT_ACTIVE;
    if (num_light) state_byte = state_byte | BIT_NUM;
    if (caps_light) state_byte = state_byte | BIT_CAPS;
    if (scroll_light) state_byte = state_byte | BIT_SCROLL;
    if (!empty) state_byte = state_byte | BIT_BUSY;
  end

  always_comb begin
    res.read_data   = '0;
    res.key_dropped = 1'b0;
    case (opcode)
      OP_PRESS, OP_RELEASE: res.key_dropped = full;
      OP_READ_STATE:        res.read_data = state_byte;
      OP_READ_DATA:         res.read_data = empty ? '0 : scan_store[head_index];
      default:              res.read_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      scan_store[tail_index] <= key_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index   <= '0;
      tail_index   <= '0;
      entry_count  <= '0;
      num_light    <= 1'b0;
      caps_light   <= 1'b0;
      scroll_light <= 1'b0;
    end else begin
      if (push) begin
        tail_index  <= tail_next;
        entry_count <= entry_count + CNT_W'(1);
      end
      if (pop) begin
        head_index  <= head_next;
        entry_count <= entry_count - CNT_W'(1);
      end
      if (take && (opcode == OP_WRITE_STATE)) begin
        num_light    <= (write_value & BIT_NUM) != '0;
        caps_light   <= (write_value & BIT_CAPS) != '0;
        scroll_light <= (write_value & BIT_SCROLL) != '0;
      end
    end
  end

  // occupancy and pointer consistency
  `KBS_NEVER(a_count_range, clk, rst, entry_count > CNT_W'(QUEUE_DEPTH))
  `KBS_ASSERT(a_ptr_match, clk, rst, (empty || full) |-> (head_index == tail_index))
  `KBS_ASSERT(a_push_count, clk, rst, push |=> (entry_count == $past(entry_count) + CNT_W'(1)))
  `KBS_ASSERT(a_pop_count, clk, rst, pop |=> (entry_count == $past(entry_count) - CNT_W'(1)))

endmodule

// ----- design/kbs_out_buf.sv -----
// two-entry output buffer: result register plus skid register
// depends on kbs_pkg
module kbs_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  kbs_pkg::result_t res_in,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output kbs_pkg::result_t res_out
);
  import kbs_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    out_free;

  assign out_free = !out_valid || out_ready;
  assign space    = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= load;
      end
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      res_out <= skid_valid ? skid : res_in;
    end else if (load) begin
      skid <= res_in;
    end
  end

endmodule

// ----- design/keyboard_scan_fifo_with_status_core.sv -----
// keyboard scan code queue with status and lock light register, top level
// depends on kbs_pkg, kbs_queue and kbs_out_buf
//
// One transfer per cycle while in_ready is high: each key event or bus
// access is decided in the cycle it is taken, against the queue and light
// registers; its result is registered, via the skid register if the output
// stalls. A two-entry output buffer keeps in_ready high while one result
// waits; in_ready drops only when the result and skid registers are full.
// The queue holds QUEUE_DEPTH entries in flip-flops; entries are not
// cleared at reset, and only written entries are ever read.
module keyboard_scan_fifo_with_status_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kbs_pkg::OP_W-1:0]    opcode,
  input  logic [kbs_pkg::CODE_W-1:0]  scan_code,
  input  logic [kbs_pkg::BYTE_W-1:0]  write_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kbs_pkg::BYTE_W-1:0]  read_data,
  output logic                        key_dropped
);
  import kbs_pkg::*;

  logic    take;
  result_t res;
  result_t res_q;

  assign take = in_valid && in_ready;

  kbs_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .opcode      (opcode),
    .scan_code   (scan_code),
    .write_value (write_value),
    .res         (res)
  );

  kbs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res_in    (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign read_data   = res_q.read_data;
  assign key_dropped = res_q.key_dropped;

endmodule

// ----- dv/tb_keyboard_scan_fifo_with_status_core.sv -----
// self-checking testbench for keyboard_scan_fifo_with_status_core: key events and bus
// accesses in, one reply per access out, checked against a cycle-free model of the queue
// depends on kbs_pkg and the keyboard_scan_fifo_with_status_core rtl
module tb_keyboard_scan_fifo_with_status_core;
  import kbs_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 4;
  localparam int MAX_WAIT       = 4;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam logic [OP_W-1:0] OP_TOP = '1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CODE_W-1:0] code;
    logic [BYTE_W-1:0] wv;
  } kbd_access_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   opcode = '0;
  logic [CODE_W-1:0] scan_code = '0;
  logic [BYTE_W-1:0] write_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] read_data;
  logic              key_dropped;

  kbd_access_t pending_accesses[$];
  result_t     due_replies[$];

  // queue and light state as seen by the bus
  logic [BYTE_W-1:0] key_entries[$];
  logic              num_on = 1'b0;
  logic              caps_on = 1'b0;
  logic              scroll_on = 1'b0;

  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          hold_rx = 1'b0;
  bit          sender_steady = 1'b0;
  bit          receiver_steady = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned drop_count = 0;
  int unsigned error_count = 0;

  keyboard_scan_fifo_with_status_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .scan_code  (scan_code),
    .write_value(write_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .key_dropped(key_dropped)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic result_t predict_reply(kbd_access_t acc);
    result_t r;
    r = '0;
    case (acc.op)
      OP_PRESS, OP_RELEASE: begin
        if (key_entries.size() >= QUEUE_DEPTH) r.key_dropped = 1'b1;
        else if (acc.op == OP_RELEASE) key_entries.push_back(BIT_BUSY | {1'b0, acc.code});
        else key_entries.push_back({1'b0, acc.code});
      end
      OP_READ_STATE: begin
        r.read_data = BIT_ACTIVE;
        if (num_on) r.read_data |= BIT_NUM;
        if (caps_on) r.read_data |= BIT_CAPS;
        if (scroll_on) r.read_data |= BIT_SCROLL;
        if (key_entries.size() != 0) r.read_data |= BIT_BUSY;
      end
      OP_WRITE_STATE: begin
        num_on = (acc.wv & BIT_NUM) != '0;
        caps_on = (acc.wv & BIT_CAPS) != '0;
        scroll_on = (acc.wv & BIT_SCROLL) != '0;
        if (key_entries.size() != 0 && (acc.wv & BIT_BUSY) == '0) void'(key_entries.pop_front());
      end
      OP_READ_DATA: begin
        if (key_entries.size() != 0) r.read_data = key_entries[0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_access(logic [OP_W-1:0] op, logic [CODE_W-1:0] code,
                            logic [BYTE_W-1:0] wv);
    kbd_access_t acc;
    acc.op = op;
    acc.code = code;
    acc.wv = wv;
    pending_accesses.push_back(acc);
  endtask

  task automatic add_key_event();
    add_access($urandom_range(0, 1) ? OP_RELEASE : OP_PRESS, CODE_W'($urandom),
               BYTE_W'($urandom));
  endtask

  // sender
  always @(negedge clk) begin
    kbd_access_t nxt;
    bit offering;
    if (!rst) begin
      offering = in_valid;
      if (in_valid && in_taken) begin
        offering = 1'b0;
        sent_count++;
        if ($urandom_range(0, 49) == 0) sender_steady = !sender_steady;
        send_gap = sender_steady ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_accesses.size() != 0) begin
          nxt = pending_accesses.pop_front();
          opcode = nxt.op;
          scan_code = nxt.code;
          write_value = nxt.wv;
          offering = 1'b1;
        end
      end
      in_valid = offering;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        if ($urandom_range(0, 49) == 0) receiver_steady = !receiver_steady;
        stall_left = receiver_steady ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready = (stall_left == 0) && !hold_rx;
    end
  end

  // long receiver hold-offs so the block backs up into its input
  initial begin
    wait (sent_count >= 300);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
    wait (sent_count >= 1100);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  // monitor and checker
  always @(posedge clk) begin
    result_t want;
    kbd_access_t acc;
    if (rst) begin
      in_taken = 1'b0;
      out_taken = 1'b0;
    end else begin
      in_taken = in_valid && in_ready;
      out_taken = out_valid && out_ready;
      if (out_taken) begin
        if (due_replies.size() == 0) begin
          $error("reply with none pending: read_data %0h key_dropped %0b", read_data,
                 key_dropped);
          error_count++;
        end else begin
          want = due_replies.pop_front();
          checked_count++;
          if (want.key_dropped) drop_count++;
          if (read_data !== want.read_data) begin
            $error("read_data expected %0h actual %0h", want.read_data, read_data);
            error_count++;
          end
          if (key_dropped !== want.key_dropped) begin
            $error("key_dropped expected %0b actual %0b", want.key_dropped, key_dropped);
            error_count++;
          end
        end
      end
      if (in_taken) begin
        acc.op = opcode;
        acc.code = scan_code;
        acc.wv = write_value;
        due_replies.push_back(predict_reply(acc));
      end
    end
  end

  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("tb_keyboard_scan_fifo_with_status_core: errors");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned start;
    // directed: empty queue, lights, fill to full, drop, keep and pop, unused codes
    add_access(OP_READ_STATE, '1, '1);
    add_access(OP_READ_DATA, '1, '1);
    add_access(OP_WRITE_STATE, '0, 8'hff);
    add_access(OP_READ_STATE, '0, '0);
    add_access(OP_PRESS, '0, '0);
    add_access(OP_RELEASE, '1, '1);
    add_access(OP_PRESS, '1, '0);
    add_access(OP_RELEASE, '0, '1);
    for (int i = 4; i < QUEUE_DEPTH; i++) add_key_event();
    add_access(OP_PRESS, 7'h2a, '0);
    add_access(OP_READ_STATE, '0, '0);
    add_access(OP_READ_DATA, '0, '0);
    add_access(OP_WRITE_STATE, '0, BIT_BUSY);
    add_access(OP_WRITE_STATE, '1, 8'h71);
    add_access(OP_READ_DATA, '0, '0);
    for (int op = OP_READ_DATA + 1; op <= OP_TOP; op++)
      add_access(OP_W'(op), CODE_W'($urandom), BYTE_W'($urandom));

    start = pending_accesses.size();
    while (pending_accesses.size() - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        repeat ($urandom_range(1, 8)) add_key_event();
      end else if (pick < 8) begin
        // polling service: status, head byte, acknowledge
        repeat ($urandom_range(1, 4)) begin
          add_access(OP_READ_STATE, CODE_W'($urandom), BYTE_W'($urandom));
          add_access(OP_READ_DATA, CODE_W'($urandom), BYTE_W'($urandom));
          add_access(OP_WRITE_STATE, CODE_W'($urandom), BYTE_W'($urandom) & ~BIT_BUSY);
        end
      end else begin
        add_access(OP_W'($urandom_range(0, OP_TOP)), CODE_W'($urandom), BYTE_W'($urandom));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_accesses.size() != 0 || in_valid || due_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d accesses with random gaps and two long output stalls", sent_count);
    $display("checked %0d replies, %0d of them key events dropped on a full queue",
             checked_count, drop_count);
    if (error_count == 0) begin
      $display("tb_keyboard_scan_fifo_with_status_core: clean");
    end else begin
      $display("tb_keyboard_scan_fifo_with_status_core: errors");
    end
    $finish;
  end

endmodule
